@@ hdl/ccfp_pkg.sv @@
package ccfp_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 64;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 7;
    localparam int IDX_W    = 6;
    localparam int EVENT_W  = 2;
    localparam int CNT_W    = 32;
    localparam int CRC_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Result word layout: header and payload fields, then the three counters.
    localparam int TDATA_BITS = 4 * BYTE_W + LEN_W + IDX_W + 3 * CNT_W;
    localparam int TDATA_W    = ((TDATA_BITS + 7) / 8) * 8;
    localparam int TUSER_W    = EVENT_W + 1;

    localparam logic [EVENT_W-1:0] EV_GOOD    = 2'd0;
    localparam logic [EVENT_W-1:0] EV_CRC_ERR = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LEN_ERR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT    = 2'd3;

    localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'hAA;
    localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 7'd64;
    localparam logic [CRC_W-1:0]  CRC_POLY_RST    = 16'h1021;
    localparam logic [CRC_W-1:0]  CRC_INIT_RST    = 16'hFFFF;

    typedef enum logic [3:0] {
        PH_WAIT,
        PH_VERSION,
        PH_COMMAND,
        PH_SEQ,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHK_HI,
        PH_CHK_LO,
        PH_DELIVER
    } phase_t;

    // One byte of an MSB-first CRC-16, eight shift steps.
    function automatic logic [CRC_W-1:0] crc16_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ poly;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hdl/crc_checked_frame_parser_top.sv @@
// Channel   Dir  Handshake          Content
// s_        in   s_tvalid/s_tready  s_tdata[7:0] received byte
// m_        out  m_tvalid/m_tready  m_tdata header, payload byte, counters;
//                                   m_tuser kind and data flag; m_tlast last
// cfg_      in   cfg_we             cfg_idx register index, cfg_wdata value
//
// A good frame with payload is read out of the payload memory through a registered read,
// one word per cycle while the output is not stalled; no input is taken until the last
// word has been delivered.
// aresetn is synchronous and active low; the payload memory is not cleared.
// A stalled output holds input only for bytes that can produce a result.
module crc_checked_frame_parser_top
    import ccfp_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] version, [15:8] command, [23:16] seq_id, [30:24] frame_length,
    // [36:31] byte_index, [44:37] data_byte, [76:45] good_frames,
    // [108:77] crc_errors, [140:109] length_errors, rest zero
    output logic [TDATA_W-1:0]    m_tdata,
    output logic [TUSER_W-1:0]    m_tuser,   // [1:0] event_res, [2] has_data
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(PAYLOAD_DEPTH);

    // Configuration registers
    logic [BYTE_W-1:0] start_byte_reg;
    logic [LEN_W-1:0]  max_payload_reg;
    logic [CRC_W-1:0]  crc_poly_reg;
    logic [CRC_W-1:0]  crc_init_reg;

    // Parser state
    phase_t            phase_reg, phase_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [BYTE_W-1:0] chk_hi_reg, chk_hi_next;
    logic [BYTE_W-1:0] hdr_ver_reg, hdr_ver_next;
    logic [BYTE_W-1:0] hdr_cmd_reg, hdr_cmd_next;
    logic [BYTE_W-1:0] hdr_seq_reg, hdr_seq_next;
    logic [LEN_W-1:0]  hdr_len_reg, hdr_len_next;
    logic [CNT_W-1:0]  ok_cnt_reg, ok_cnt_next;
    logic [CNT_W-1:0]  crc_cnt_reg, crc_cnt_next;
    logic [CNT_W-1:0]  len_cnt_reg, len_cnt_next;

    // Delivery read pipeline
    logic [LEN_W-1:0]  issue_idx_reg, issue_idx_next;
    logic [LEN_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              pend_reg, pend_next;

    // Payload memory
    logic [BYTE_W-1:0] payload_mem [PAYLOAD_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              mem_we;
    logic              rd_en;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0]   out_data_reg, out_data_next;
    logic [TUSER_W-1:0]   out_user_reg, out_user_next;
    logic                 out_last_reg, out_last_next;

    logic              out_free;
    logic              in_acc;
    logic              emit_phase;
    logic [LEN_W-1:0]  limit;
    logic              len_bad;
    logic              crc_ok;
    logic [CRC_W-1:0]  crc_upd;
    logic              issue;
    logic              deliver_ld;
    logic              deliver_last;

    logic              ld_out;
    logic [EVENT_W-1:0] ld_event;
    logic [LEN_W-1:0]  ld_len;
    logic [IDX_W-1:0]  ld_idx;
    logic [BYTE_W-1:0] ld_byte;
    logic              ld_has;

    assign out_free   = !out_valid_reg || m_tready;
    assign emit_phase = (phase_reg == PH_LENGTH) || (phase_reg == PH_CHK_LO);
    assign s_tready   = (phase_reg != PH_DELIVER) && (!emit_phase || out_free);
    assign in_acc     = s_tvalid && s_tready;

    assign limit   = (max_payload_reg < DEPTH_LEN) ? max_payload_reg : DEPTH_LEN;
    assign len_bad = s_tdata > {1'b0, limit};
    assign crc_ok  = {chk_hi_reg, s_tdata} == crc_reg;
    assign crc_upd = crc16_byte(crc_reg, s_tdata, crc_poly_reg);

    // Reads are issued only when no word is waiting or the word already waiting can leave this cycle.
    assign issue = (phase_reg == PH_DELIVER) && (issue_idx_reg < hdr_len_reg)
                   && (!pend_reg || out_free);
    assign deliver_ld   = (phase_reg == PH_DELIVER) && pend_reg && out_free;
    assign deliver_last = (pend_idx_reg + 7'd1) == hdr_len_reg;

    assign rd_en  = issue;
    assign mem_we = in_acc && (phase_reg == PH_PAYLOAD);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_WAIT: begin
                if (in_acc && s_tdata == start_byte_reg) begin
                    phase_next = PH_VERSION;
                end
            end
            PH_VERSION: begin
                if (in_acc) begin
                    phase_next = PH_COMMAND;
                end
            end
            PH_COMMAND: begin
                if (in_acc) begin
                    phase_next = PH_SEQ;
                end
            end
            PH_SEQ: begin
                if (in_acc) begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                if (in_acc) begin
                    if (len_bad) begin
                        phase_next = PH_WAIT;
                    end else if (s_tdata == 8'd0) begin
                        phase_next = PH_CHK_HI;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (in_acc && (fill_reg + 7'd1) >= hdr_len_reg) begin
                    phase_next = PH_CHK_HI;
                end
            end
            PH_CHK_HI: begin
                if (in_acc) begin
                    phase_next = PH_CHK_LO;
                end
            end
            PH_CHK_LO: begin
                if (in_acc) begin
                    if (crc_ok && hdr_len_reg != 7'd0) begin
                        phase_next = PH_DELIVER;
                    end else begin
                        phase_next = PH_WAIT;
                    end
                end
            end
            PH_DELIVER: begin
                if (deliver_ld && deliver_last) begin
                    phase_next = PH_WAIT;
                end
            end
            default: begin
                phase_next = PH_WAIT;
            end
        endcase
    end

    // Datapath and result selection
    always_comb begin
        crc_next       = crc_reg;
        fill_next      = fill_reg;
        chk_hi_next    = chk_hi_reg;
        hdr_ver_next   = hdr_ver_reg;
        hdr_cmd_next   = hdr_cmd_reg;
        hdr_seq_next   = hdr_seq_reg;
        hdr_len_next   = hdr_len_reg;
        ok_cnt_next    = ok_cnt_reg;
        crc_cnt_next   = crc_cnt_reg;
        len_cnt_next   = len_cnt_reg;
        issue_idx_next = issue_idx_reg;
        ld_out         = 1'b0;
        ld_event       = EV_GOOD;
        ld_len         = '0;
        ld_idx         = '0;
        ld_byte        = '0;
        ld_has         = 1'b0;
        out_last_next  = out_last_reg;

        case (phase_reg)
            PH_WAIT: begin
                if (in_acc && s_tdata == start_byte_reg) begin
                    crc_next    = crc_init_reg;
                    fill_next   = '0;
                    chk_hi_next = '0;
                end
            end
            PH_VERSION: begin
                if (in_acc) begin
                    hdr_ver_next = s_tdata;
                    crc_next     = crc_upd;
                end
            end
            PH_COMMAND: begin
                if (in_acc) begin
                    hdr_cmd_next = s_tdata;
                    crc_next     = crc_upd;
                end
            end
            PH_SEQ: begin
                if (in_acc) begin
                    hdr_seq_next = s_tdata;
                    crc_next     = crc_upd;
                end
            end
            PH_LENGTH: begin
                if (in_acc) begin
                    if (len_bad) begin
                        len_cnt_next = len_cnt_reg + 32'd1;
                        crc_next     = crc_init_reg;
                        fill_next    = '0;
                        chk_hi_next  = '0;
                        ld_out       = 1'b1;
                        ld_event     = EV_LEN_ERR;
                    end else begin
                        hdr_len_next = s_tdata[LEN_W-1:0];
                        crc_next     = crc_upd;
                        fill_next    = '0;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (in_acc) begin
                    fill_next = fill_reg + 7'd1;
                    crc_next  = crc_upd;
                end
            end
            PH_CHK_HI: begin
                if (in_acc) begin
                    chk_hi_next = s_tdata;
                end
            end
            PH_CHK_LO: begin
                if (in_acc) begin
                    crc_next    = crc_init_reg;
                    fill_next   = '0;
                    chk_hi_next = '0;
                    if (crc_ok) begin
                        ok_cnt_next    = ok_cnt_reg + 32'd1;
                        issue_idx_next = '0;
                        // An empty frame gives its single result at once.
                        ld_out = (hdr_len_reg == 7'd0);
                    end else begin
                        crc_cnt_next = crc_cnt_reg + 32'd1;
                        ld_out       = 1'b1;
                        ld_event     = EV_CRC_ERR;
                        ld_len       = hdr_len_reg;
                    end
                end
            end
            PH_DELIVER: begin
                if (issue) begin
                    issue_idx_next = issue_idx_reg + 7'd1;
                end
                if (deliver_ld) begin
                    ld_out  = 1'b1;
                    ld_len  = hdr_len_reg;
                    ld_idx  = pend_idx_reg[IDX_W-1:0];
                    ld_byte = rd_data_reg;
                    ld_has  = 1'b1;
                end
            end
            default: begin
                crc_next = crc_init_reg;
            end
        endcase

        if (ld_out) begin
            out_last_next = (phase_reg == PH_DELIVER) ? deliver_last : 1'b1;
        end
    end

    // Read pipeline bookkeeping: a fetched word waits while the output is full.
    always_comb begin
        pend_next     = issue || (pend_reg && !out_free);
        pend_idx_next = issue ? issue_idx_reg : pend_idx_reg;
    end

    always_comb begin
        out_valid_next = ld_out || (out_valid_reg && !m_tready);
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (ld_out) begin
            out_data_next = TDATA_W'({len_cnt_next, crc_cnt_next, ok_cnt_next, ld_byte,
                                      ld_idx, ld_len, hdr_seq_reg, hdr_cmd_reg,
                                      hdr_ver_reg});
            out_user_next = {ld_has, ld_event};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg  <= START_BYTE_RST;
            max_payload_reg <= MAX_PAYLOAD_RST;
            crc_poly_reg    <= CRC_POLY_RST;
            crc_init_reg    <= CRC_INIT_RST;
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_START_BYTE:  start_byte_reg  <= cfg_wdata[BYTE_W-1:0];
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_wdata[LEN_W-1:0];
                CFG_CRC_POLY:    crc_poly_reg    <= cfg_wdata[CRC_W-1:0];
                CFG_CRC_INIT:    crc_init_reg    <= cfg_wdata[CRC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_WAIT;
            crc_reg       <= CRC_INIT_RST;
            fill_reg      <= '0;
            chk_hi_reg    <= '0;
            hdr_ver_reg   <= '0;
            hdr_cmd_reg   <= '0;
            hdr_seq_reg   <= '0;
            hdr_len_reg   <= '0;
            ok_cnt_reg    <= '0;
            crc_cnt_reg   <= '0;
            len_cnt_reg   <= '0;
            issue_idx_reg <= '0;
            pend_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            crc_reg       <= crc_next;
            fill_reg      <= fill_next;
            chk_hi_reg    <= chk_hi_next;
            hdr_ver_reg   <= hdr_ver_next;
            hdr_cmd_reg   <= hdr_cmd_next;
            hdr_seq_reg   <= hdr_seq_next;
            hdr_len_reg   <= hdr_len_next;
            ok_cnt_reg    <= ok_cnt_next;
            crc_cnt_reg   <= crc_cnt_next;
            len_cnt_reg   <= len_cnt_next;
            issue_idx_reg <= issue_idx_next;
            pend_idx_reg  <= pend_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            payload_mem[fill_reg[ADDR_W-1:0]] <= s_tdata;
        end
        if (rd_en) begin
            rd_data_reg <= payload_mem[issue_idx_reg[ADDR_W-1:0]];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule
